@@ rtl/led_chain_color_frame_top_assert.svh @@
// ----------------------------------------------------------------------------
// LED chain frame assertion macros
// Shorthand for the clocked checks of the LED chain frame generator.
// ----------------------------------------------------------------------------
`ifndef LED_CHAIN_COLOR_FRAME_TOP_ASSERT_SVH
`define LED_CHAIN_COLOR_FRAME_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LCCF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCCF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lccf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED chain frame package
// Constants, codes and helper functions of the LED chain frame generator.
// ----------------------------------------------------------------------------
package lccf_pkg;

  localparam int LEN_W   = 6;
  localparam int IDX_W   = 5;
  localparam int COLOR_W = 13;
  localparam int WORD_W  = 32;

  // Fixed point unit: 4096 stands for 1.0.
  localparam logic [COLOR_W-1:0] HSL_ONE    = 13'd4096;
  localparam logic [COLOR_W-1:0] HSL_HALF   = 13'd2048;
  localparam logic signed [14:0] THIRD_TURN = 15'sd1365;
  localparam logic [7:0]         BYTE_MAX   = 8'd255;
  localparam logic [7:0]         FLAG_BASE  = 8'hc0;

  // Operation codes.
  localparam logic OP_RGB = 1'b0;
  localparam logic OP_HSL = 1'b1;

  // Color channel codes for the conversion sequencer.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Piece of the hue curve that a channel falls on.
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_FLAT,
    SEG_FALL,
    SEG_LOW
  } hue_seg_t;

  // Clamp an HSL input to one full unit.
  function automatic logic [COLOR_W-1:0] clamp_unit(input logic [COLOR_W-1:0] v);
    clamp_unit = (v > HSL_ONE) ? HSL_ONE : v;
  endfunction

  // Saturate a direct color input to one byte.
  function automatic logic [7:0] sat_byte(input logic [COLOR_W-1:0] v);
    sat_byte = (v > 13'(BYTE_MAX)) ? BYTE_MAX : v[7:0];
  endfunction

  // Build one LED word: flag, blue, green, red.
  function automatic logic [WORD_W-1:0] led_word(input logic [7:0] r,
                                                 input logic [7:0] g,
                                                 input logic [7:0] b);
    logic [7:0] flag;
    flag = FLAG_BASE | {2'b00, ~b[7:6], ~g[7:6], ~r[7:6]};
    led_word = {flag, b, g, r};
  endfunction

endpackage

@@ rtl/led_chain_color_frame_top.sv @@
`timescale 1ns / 1ps
// Each frame is n+2 words back to back: head, n LED words, tail. The head word follows the store write.
// A new command is taken only in idle, once the tail word is out; n = active chain length.
// The HSL path runs four passes through one shared 14x14 multiplier, one step per cycle.
// Frame words come from the color store one read per cycle; the receiver cannot stall.
// Reset: colors read as black through per-entry valid bits, chain length 1, no clearing pass.
// ----------------------------------------------------------------------------
// LED chain color frame generator
// Stores one color per LED, converts HSL in fixed point, and sends each frame.
// ----------------------------------------------------------------------------
module led_chain_color_frame_top #(
  parameter int MAX_LEDS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Command channel.
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_operation,
  input  logic [lccf_pkg::IDX_W-1:0]      in_led_index,
  input  logic [lccf_pkg::COLOR_W-1:0]    in_color_first,
  input  logic [lccf_pkg::COLOR_W-1:0]    in_color_second,
  input  logic [lccf_pkg::COLOR_W-1:0]    in_color_third,
  // Result channel.
  output logic                            out_strobe,
  output logic [lccf_pkg::WORD_W-1:0]     out_frame_word,
  output logic                            out_last_word,
  // Configuration channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lccf_pkg::LEN_W-1:0]      cfg_chain_length
);
  import lccf_pkg::*;

`include "led_chain_color_frame_top_assert.svh"

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = $clog2(MAX_LEDS + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEDS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_QMUL,
    S_QFIN,
    S_CMUL,
    S_CFIN,
    S_WRITE,
    S_HEAD,
    S_LEDS,
    S_TAIL
  } state_t;

  // Control registers.
  state_t                 state_r, state_nxt;
  logic [1:0]             ch_r, ch_nxt;
  logic [CW-1:0]          i_r, i_nxt;
  logic [LEN_W-1:0]       chain_len_r;
  logic                   out_strobe_r, out_strobe_nxt;
  logic                   out_last_word_r, out_last_word_nxt;
  logic [MAX_LEDS-1:0]    vld_r;

  // Datapath registers.
  logic [IDX_W-1:0]       idx_r;
  logic [COLOR_W-1:0]     h_r, s_r, l_r;
  logic signed [14:0]     q_r, p_r;
  logic [13:0]            d_r;
  logic [27:0]            prod_r;
  hue_seg_t               seg_r, seg_nxt;
  logic [7:0]             red_r, grn_r, blu_r;
  logic [WORD_W-1:0]      out_frame_word_r, out_frame_word_nxt;

  // Color store.
  logic [23:0]            mem [MAX_LEDS];
  logic [23:0]            rd_data_r;
  logic                   rd_vld_r;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   mem_we;
  logic [AW-1:0]          wr_addr;

  // Shared multiplier and helpers.
  logic [13:0]            mul_a, mul_b;
  logic [27:0]            mul_p;
  logic [13:0]            prod_sh;
  logic signed [14:0]     q_w, p_w, dq_w;
  logic signed [14:0]     t_raw, t_wrap;
  logic [12:0]            t13;
  logic [15:0]            t6;
  logic [13:0]            factor;
  logic signed [14:0]     v_w;
  logic [13:0]            u_w;
  logic [21:0]            scaled;
  logic [7:0]             chan_byte;
  logic [CW-1:0]          n_w;
  logic                   accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  // The chain length only changes between frames.
  assign cfg_ready = !busy;

  assign out_strobe     = out_strobe_r;
  assign out_last_word  = out_last_word_r;
  assign out_frame_word = out_frame_word_r;

  // Active chain length, limited to the store depth.
  assign n_w = (chain_len_r > LEN_MAX) ? CW'(MAX_LEDS) : CW'(chain_len_r);

  // The one multiplier; its operands follow the sequencer step.
  always_comb begin
    mul_a = d_r;
    mul_b = factor;
    if (state_r == S_QMUL) begin
      mul_a = 14'(l_r);
      mul_b = (l_r < HSL_HALF) ? (14'(HSL_ONE) + 14'(s_r)) : 14'(s_r);
    end
  end
  assign mul_p   = 28'(mul_a) * 28'(mul_b);
  assign prod_sh = prod_r[25:12];

  // Finish q and p from the registered product.
  always_comb begin
    if (l_r < HSL_HALF) begin
      q_w = $signed({1'b0, prod_sh});
    end else begin
      q_w = $signed({2'b00, l_r}) + $signed({2'b00, s_r}) - $signed({1'b0, prod_sh});
    end
    p_w  = $signed({1'b0, l_r, 1'b0}) - q_w;
    dq_w = q_w - p_w;
  end

  // Hue position of the current channel, wrapped into one turn, and its segment.
  always_comb begin
    case (ch_r)
      CH_RED:   t_raw = $signed({2'b00, h_r}) + THIRD_TURN;
      CH_GREEN: t_raw = $signed({2'b00, h_r});
      default:  t_raw = $signed({2'b00, h_r}) - THIRD_TURN;
    endcase
    if (t_raw < 0) begin
      t_wrap = t_raw + $signed({2'b00, HSL_ONE});
    end else if (t_raw > $signed({2'b00, HSL_ONE})) begin
      t_wrap = t_raw - $signed({2'b00, HSL_ONE});
    end else begin
      t_wrap = t_raw;
    end
    t13 = t_wrap[12:0];
    t6  = 16'({t13, 2'b00}) + 16'({t13, 1'b0});
    if (t6 < 16'(HSL_ONE)) begin
      seg_nxt = SEG_RISE;
      factor  = t6[13:0];
    end else if (t13 < HSL_HALF) begin
      seg_nxt = SEG_FLAT;
      factor  = 14'd0;
    end else if (t6 < 16'd16384) begin
      seg_nxt = SEG_FALL;
      factor  = 14'(16'd16384 - t6);
    end else begin
      seg_nxt = SEG_LOW;
      factor  = 14'd0;
    end
  end

  // Channel value to byte: (v * 255) >> 12, saturated.
  always_comb begin
    case (seg_r)
      SEG_RISE: v_w = p_r + $signed({1'b0, prod_sh});
      SEG_FALL: v_w = p_r + $signed({1'b0, prod_sh});
      SEG_FLAT: v_w = q_r;
      default:  v_w = p_r;
    endcase
    u_w       = (v_w < 0) ? 14'd0 : v_w[13:0];
    scaled    = {u_w, 8'b0} - {8'b0, u_w};
    chan_byte = (scaled[21:12] > 10'(BYTE_MAX)) ? BYTE_MAX : scaled[19:12];
  end

  // Sequencer: next state, store write, word output and store read.
  always_comb begin
    state_nxt          = state_r;
    ch_nxt             = ch_r;
    i_nxt              = i_r;
    out_strobe_nxt     = 1'b0;
    out_last_word_nxt  = 1'b0;
    out_frame_word_nxt = '0;
    rd_en              = 1'b0;
    rd_addr            = '0;
    mem_we             = 1'b0;
    wr_addr            = AW'(idx_r);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ch_nxt    = CH_RED;
          state_nxt = (in_operation == OP_HSL) ? S_QMUL : S_WRITE;
        end
      end
      S_QMUL: begin
        state_nxt = S_QFIN;
      end
      S_QFIN: begin
        state_nxt = S_CMUL;
      end
      S_CMUL: begin
        state_nxt = S_CFIN;
      end
      S_CFIN: begin
        if (ch_r == CH_BLUE) begin
          state_nxt = S_WRITE;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = S_CMUL;
        end
      end
      S_WRITE: begin
        mem_we    = (32'(idx_r) < 32'(MAX_LEDS));
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        out_strobe_nxt = 1'b1;
        i_nxt          = '0;
        rd_en          = (n_w != '0);
        state_nxt      = (n_w == '0) ? S_TAIL : S_LEDS;
      end
      S_LEDS: begin
        out_strobe_nxt = 1'b1;
        if (rd_vld_r) begin
          out_frame_word_nxt = led_word(rd_data_r[7:0], rd_data_r[15:8], rd_data_r[23:16]);
        end else begin
          out_frame_word_nxt = led_word(8'd0, 8'd0, 8'd0);
        end
        if (i_r == n_w - CW'(1)) begin
          state_nxt = S_TAIL;
        end else begin
          i_nxt   = i_r + CW'(1);
          rd_en   = 1'b1;
          rd_addr = i_nxt[AW-1:0];
        end
      end
      S_TAIL: begin
        out_strobe_nxt    = 1'b1;
        out_last_word_nxt = 1'b1;
        state_nxt         = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      ch_r             <= CH_RED;
      i_r              <= '0;
      chain_len_r      <= LEN_W'(1);
      out_strobe_r     <= 1'b0;
      out_last_word_r  <= 1'b0;
      out_frame_word_r <= '0;
      vld_r            <= '0;
    end else begin
      state_r          <= state_nxt;
      ch_r             <= ch_nxt;
      i_r              <= i_nxt;
      out_strobe_r     <= out_strobe_nxt;
      out_last_word_r  <= out_last_word_nxt;
      out_frame_word_r <= out_frame_word_nxt;
      if (cfg_valid && cfg_ready) begin
        chain_len_r <= cfg_chain_length;
      end
      if (mem_we) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= in_led_index;
      h_r   <= clamp_unit(in_color_first);
      s_r   <= clamp_unit(in_color_second);
      l_r   <= clamp_unit(in_color_third);
      red_r <= sat_byte(in_color_first);
      grn_r <= sat_byte(in_color_second);
      blu_r <= sat_byte(in_color_third);
    end
    if (state_r == S_QMUL || state_r == S_CMUL) begin
      prod_r <= mul_p;
    end
    if (state_r == S_QFIN) begin
      q_r <= q_w;
      p_r <= p_w;
      d_r <= (dq_w < 0) ? 14'd0 : dq_w[13:0];
    end
    if (state_r == S_CMUL) begin
      seg_r <= seg_nxt;
    end
    if (state_r == S_CFIN) begin
      case (ch_r)
        CH_RED:   red_r <= chan_byte;
        CH_GREEN: grn_r <= chan_byte;
        default:  blu_r <= chan_byte;
      endcase
    end
  end

  // Color store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {blu_r, grn_r, red_r};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  // Checks.
  `LCCF_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy && !out_strobe,
                   "accepted command did not raise busy")
  `LCCF_ASSERT_NXT(a_tail_last, clk, rst_n, state_r == S_TAIL,
                   out_strobe && out_last_word && (out_frame_word == '0),
                   "closing word missing after tail step")
  `LCCF_ASSERT_IMP(a_led_range, clk, rst_n, state_r == S_LEDS, i_r < n_w,
                   "LED word index beyond chain length")
  `LCCF_ASSERT_IMP(a_last_strobe, clk, rst_n, out_last_word, out_strobe && !busy,
                   "last word outside a strobe or while busy")
  `LCCF_ASSERT_NXT(a_write_head, clk, rst_n, state_r == S_WRITE,
                   state_r == S_HEAD && !out_strobe,
                   "store write not followed by frame head")

endmodule
